>>> src/fdp_pkg.sv
// ----------------------------------------------------------------------------
// fdp_pkg
// shared types and constants of the frame deadline pacer
// ----------------------------------------------------------------------------
`default_nettype none

package fdp_pkg;

    localparam int unsigned NOW_W     = 64;
    localparam int unsigned PERIOD_W  = 32;
    localparam int unsigned STRETCH_W = 16;
    localparam int unsigned LAG_W     = 8;
    localparam int unsigned DELAY_W   = 33;
    localparam int unsigned CNT32_W   = 32;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam int unsigned SMAG_W    = 12;
    localparam int unsigned LAGP_W    = LAG_W + PERIOD_W;
    localparam int unsigned MAGP_W    = PERIOD_W + SMAG_W;
    localparam int unsigned MAG_W     = MAGP_W - 16;

    localparam logic [SMAG_W-1:0] MAX_SYNC_Q16 = 12'd3277;
    localparam logic [NOW_W-1:0]  WINDOW_NS    = 64'd1000000000;
    localparam logic [29:0]       NS_PER_SEC   = 30'd1000000000;
    localparam int unsigned       PROD_W       = CNT32_W + 30;
    localparam int unsigned       RATE_SHIFT   = 8;

    localparam int unsigned DIV_W     = PROD_W + RATE_SHIFT;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIV_W);

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned OUT_USER_W = 1;

    localparam logic [1:0] OP_FRAME_END = 2'd0;
    localparam logic [1:0] OP_RESYNC    = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_THROTTLE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_STRETCH  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LAG  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LIM,
        ST_DROP,
        ST_ACCT,
        ST_MUL,
        ST_RDIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                done;
        logic [CNT32_W-1:0]  quot;
    } t_div_res;

endpackage

`default_nettype wire

>>> src/fdp_div.sv
// ----------------------------------------------------------------------------
// fdp_div
// shift-subtract divider, one quotient bit per cycle, quotient saturated to
// 32 bits
// ----------------------------------------------------------------------------
`default_nettype none

module fdp_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [fdp_pkg::DIV_W-1:0]     i_dividend,
    input  wire logic [fdp_pkg::NOW_W-1:0]     i_divisor,
    output fdp_pkg::t_div_res                  o_res
);
    import fdp_pkg::*;

    logic [DIV_W-1:0]     r_dvd, n_dvd;
    logic [NOW_W-1:0]     r_den, n_den;
    logic [NOW_W-1:0]     r_rem, n_rem;
    logic [CNT32_W-1:0]   r_quo, n_quo;
    logic                 r_sat, n_sat;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;

    logic [NOW_W:0]       rem_ext;
    logic [NOW_W:0]       diff;
    logic                 ge;

    always_comb begin
        rem_ext = {r_rem, r_dvd[DIV_W-1]};
        diff    = rem_ext - {1'b0, r_den};
        ge      = rem_ext >= {1'b0, r_den};

        n_dvd  = r_dvd;
        n_den  = r_den;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_dvd = i_dividend;
            n_den = i_divisor;
            n_rem = '0;
            n_quo = '0;
            n_sat = 1'b0;
            n_cnt = DIV_STEPS;
        end else if (r_cnt != '0) begin
            n_dvd  = {r_dvd[DIV_W-2:0], 1'b0};
            n_rem  = ge ? diff[NOW_W-1:0] : rem_ext[NOW_W-1:0];
            n_sat  = r_sat | r_quo[CNT32_W-1];
            n_quo  = {r_quo[CNT32_W-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_dvd <= n_dvd;
        r_den <= n_den;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_sat <= n_sat;
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_sat ? '1 : r_quo;

endmodule

`default_nettype wire

>>> src/frame_deadline_pacer.sv
// ----------------------------------------------------------------------------
// frame_deadline_pacer
// states: every beat passes EVAL and ends in DONE; an active frame
//   end adds ACCT, and LIM before it when throttled; a lag write-off adds
//   DROP and a window close MUL and RDIV on the shared one-bit-per-cycle
//   divider; DONE waits for the output register to be free
// throughput: one item at a time, the next beat is taken the cycle after the
//   result enters the output register
// reset: synchronous active low, resets the state, pacing and config registers
// ----------------------------------------------------------------------------
`default_nettype none

module frame_deadline_pacer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fdp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [fdp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // now_ns
    input  wire logic [fdp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation
    input  wire logic [fdp_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // delay_ns, frames_written_off, measured_rate, zero pad
    output      logic [fdp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // rate_updated
    output      logic [fdp_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import fdp_pkg::*;

    t_state r_state, n_state;

    logic [PERIOD_W-1:0]  r_period;
    logic                 r_throttle;
    logic [STRETCH_W-1:0] r_stretch;
    logic [LAG_W-1:0]     r_max_lag;

    logic [NOW_W-1:0]     r_nd, n_nd;
    logic [NOW_W-1:0]     r_ws, n_ws;
    logic [CNT32_W-1:0]   r_wf, n_wf;
    logic [CNT32_W-1:0]   r_rate, n_rate;
    logic                 r_running, n_running;

    logic [1:0]           r_op, n_op;
    logic [NOW_W-1:0]     r_now, n_now;
    logic [LAGP_W-1:0]    r_lag, n_lag;
    logic [MAG_W-1:0]     r_mag, n_mag;
    logic                 r_sneg, n_sneg;
    logic [NOW_W-1:0]     r_acct_t, n_acct_t;
    logic [NOW_W-1:0]     r_elapsed, n_elapsed;
    logic [DELAY_W-1:0]   r_delay, n_delay;
    logic [CNT32_W-1:0]   r_dropped, n_dropped;
    logic                 r_updated, n_updated;

    logic                 r_out_valid, n_out_valid;
    logic [DELAY_W-1:0]   r_o_delay, n_o_delay;
    logic [CNT32_W-1:0]   r_o_dropped, n_o_dropped;
    logic [CNT32_W-1:0]   r_o_rate, n_o_rate;
    logic                 r_o_updated, n_o_updated;

    logic                 in_beat;
    logic                 out_free;
    logic                 active;
    logic [STRETCH_W-1:0] s_abs;
    logic [SMAG_W-1:0]    s_clamp;
    logic [MAGP_W-1:0]    mag_prod;
    logic [NOW_W-1:0]     limit;
    logic                 over_lag;
    logic [NOW_W-1:0]     stretched;
    logic [NOW_W-1:0]     d_diff;
    logic [NOW_W-1:0]     elapsed;
    logic                 win_closed;
    logic [CNT32_W-1:0]   wf_inc;
    logic [PROD_W-1:0]    rate_prod;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [NOW_W-1:0]     div_divisor;
    t_div_res             div_res;

    fdp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= '0;
            r_throttle <= 1'b0;
            r_stretch  <= '0;
            r_max_lag  <= LAG_W'(5);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PERIOD:   r_period   <= i_cfg_data[PERIOD_W-1:0];
                REG_THROTTLE: r_throttle <= i_cfg_data[0];
                REG_STRETCH:  r_stretch  <= i_cfg_data[STRETCH_W-1:0];
                REG_MAX_LAG:  r_max_lag  <= i_cfg_data[LAG_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign active   = r_running && (r_period != '0);

    always_comb begin
        s_abs     = r_stretch[STRETCH_W-1] ? (~r_stretch + 1'b1) : r_stretch;
        s_clamp   = (s_abs > STRETCH_W'(MAX_SYNC_Q16)) ? MAX_SYNC_Q16 : s_abs[SMAG_W-1:0];
        mag_prod  = MAGP_W'(r_period) * MAGP_W'(s_clamp);
        limit     = r_nd + NOW_W'(r_lag);
        over_lag  = r_now > limit;
        stretched = r_sneg ? (NOW_W'(r_period) - NOW_W'(r_mag))
                           : (NOW_W'(r_period) + NOW_W'(r_mag));
        d_diff    = r_nd - r_now;
        elapsed   = r_acct_t - r_ws;
        win_closed = elapsed >= WINDOW_NS;
        wf_inc    = (r_wf == '1) ? r_wf : r_wf + 1'b1;
        rate_prod = PROD_W'(r_wf) * PROD_W'(NS_PER_SEC);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_op == OP_FRAME_END && active) begin
                    n_state = r_throttle ? ST_LIM : ST_ACCT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_LIM: begin
                n_state = over_lag ? ST_DROP : ST_ACCT;
            end
            ST_DROP: begin
                if (div_res.done) n_state = ST_ACCT;
            end
            ST_ACCT: begin
                n_state = win_closed ? ST_MUL : ST_DONE;
            end
            ST_MUL: begin
                n_state = ST_RDIV;
            end
            ST_RDIV: begin
                if (div_res.done) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_nd        = r_nd;
        n_ws        = r_ws;
        n_wf        = r_wf;
        n_rate      = r_rate;
        n_running   = r_running;
        n_op        = r_op;
        n_now       = r_now;
        n_lag       = r_lag;
        n_mag       = r_mag;
        n_sneg      = r_sneg;
        n_acct_t    = r_acct_t;
        n_elapsed   = r_elapsed;
        n_delay     = r_delay;
        n_dropped   = r_dropped;
        n_updated   = r_updated;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_o_delay   = r_o_delay;
        n_o_dropped = r_o_dropped;
        n_o_rate    = r_o_rate;
        n_o_updated = r_o_updated;
        div_start    = 1'b0;
        div_dividend = {{(DIV_W-NOW_W){1'b0}}, r_now - r_nd};
        div_divisor  = NOW_W'(r_period);

        unique case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_op      = s_axis_tuser;
                    n_now     = s_axis_tdata;
                    n_delay   = '0;
                    n_dropped = '0;
                    n_updated = 1'b0;
                end
            end
            ST_EVAL: begin
                n_lag    = LAGP_W'(r_max_lag) * LAGP_W'(r_period);
                n_mag    = mag_prod[MAGP_W-1:16];
                n_sneg   = r_stretch[STRETCH_W-1];
                n_acct_t = r_now;
                unique case (r_op)
                    OP_START: begin
                        n_nd      = r_now + NOW_W'(r_period);
                        n_running = 1'b1;
                        n_ws      = r_now;
                        n_wf      = '0;
                        n_rate    = '0;
                    end
                    OP_RESYNC: begin
                        if (r_running) begin
                            n_nd = r_now + NOW_W'(r_period);
                            n_ws = r_now;
                            n_wf = '0;
                        end
                    end
                    default: ;
                endcase
            end
            ST_LIM: begin
                if (over_lag) begin
                    div_start = 1'b1;
                end else begin
                    if (r_now < r_nd) begin
                        n_delay = (d_diff[NOW_W-1:DELAY_W] != '0) ? '1
                                                                  : d_diff[DELAY_W-1:0];
                    end
                    n_nd     = r_nd + stretched;
                    n_acct_t = (r_now > r_nd) ? r_now : r_nd;
                end
            end
            ST_DROP: begin
                if (div_res.done) begin
                    n_dropped = div_res.quot;
                    n_nd      = r_now + NOW_W'(r_period);
                    n_acct_t  = r_now;
                end
            end
            ST_ACCT: begin
                n_wf      = wf_inc;
                n_elapsed = elapsed;
            end
            ST_MUL: begin
                div_start    = 1'b1;
                div_dividend = {rate_prod, {RATE_SHIFT{1'b0}}};
                div_divisor  = r_elapsed;
            end
            ST_RDIV: begin
                if (div_res.done) begin
                    n_rate    = div_res.quot;
                    n_ws      = r_acct_t;
                    n_wf      = '0;
                    n_updated = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_delay   = r_delay;
                    n_o_dropped = r_dropped;
                    n_o_rate    = r_rate;
                    n_o_updated = r_updated;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_nd        <= '0;
            r_ws        <= '0;
            r_wf        <= '0;
            r_rate      <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nd        <= n_nd;
            r_ws        <= n_ws;
            r_wf        <= n_wf;
            r_rate      <= n_rate;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
        end
        r_op        <= n_op;
        r_now       <= n_now;
        r_lag       <= n_lag;
        r_mag       <= n_mag;
        r_sneg      <= n_sneg;
        r_acct_t    <= n_acct_t;
        r_elapsed   <= n_elapsed;
        r_delay     <= n_delay;
        r_dropped   <= n_dropped;
        r_updated   <= n_updated;
        r_o_delay   <= n_o_delay;
        r_o_dropped <= n_o_dropped;
        r_o_rate    <= n_o_rate;
        r_o_updated <= n_o_updated;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - DELAY_W - 2*CNT32_W){1'b0}},
                            r_o_rate, r_o_dropped, r_o_delay};
    assign m_axis_tuser  = r_o_updated;

endmodule

`default_nettype wire
